/* rtl/lpfd_pkg.sv */
`default_nettype none

package lpfd_pkg;

  localparam int unsigned TYPE_VERSION_BYTES = 2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LONG    = 2'd1,
    ST_SHORT   = 2'd2,
    ST_VERSION = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAX_BODY    = 2'd0,
    CFG_EXP_VERSION = 2'd1,
    CFG_BIG_ENDIAN  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [31:0] max_body;
    logic [7:0]  expected_version;
    logic        length_big_endian;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic [7:0]  message_type;
    logic        frame_last;
    status_t     status;
    logic [31:0] body_length;
  } result_t;

endpackage

`default_nettype wire

/* rtl/lpfd_parse.sv */
`default_nettype none

module lpfd_parse (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire lpfd_pkg::cfg_t   cfg,
  output lpfd_pkg::result_t     res,
  output logic                  stuck
);
  import lpfd_pkg::*;

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_VERSION,
    PH_TYPE,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  header_index_r, header_index_nxt;
  logic [31:0] length_value_r, length_value_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  frame_type_r, frame_type_nxt;
  logic        version_good_r, version_good_nxt;
  logic        stuck_r, stuck_nxt;
  logic        final_byte;
  logic        next_frame;

  localparam logic [31:0] TV_BYTES = 32'(TYPE_VERSION_BYTES);

  always_comb begin
    phase_nxt        = phase_r;
    header_index_nxt = header_index_r;
    length_value_nxt = length_value_r;
    bytes_left_nxt   = bytes_left_r;
    frame_type_nxt   = frame_type_r;
    version_good_nxt = version_good_r;
    stuck_nxt        = stuck_r;
    next_frame       = 1'b0;
    final_byte       = (bytes_left_r <= 32'd1);
    res              = '0;
    res.status       = ST_OK;

    if (!stuck_r) begin
      unique case (phase_r)
        PH_LENGTH: begin
          if (cfg.length_big_endian) begin
            length_value_nxt = {length_value_r[23:0], data_byte};
          end else begin
            length_value_nxt = length_value_r | ({24'd0, data_byte} << {header_index_r, 3'b000});
          end
          if (header_index_r == 2'd3) begin
            header_index_nxt = 2'd0;
            phase_nxt        = PH_VERSION;
          end else begin
            header_index_nxt = header_index_r + 2'd1;
          end
        end
        PH_VERSION: begin
          version_good_nxt = (data_byte == cfg.expected_version);
          phase_nxt        = PH_TYPE;
        end
        PH_TYPE: begin
          frame_type_nxt = data_byte;
          if (length_value_r > cfg.max_body) begin
            res.emit       = 1'b1;
            res.frame_last = 1'b1;
            res.status     = ST_LONG;
            stuck_nxt      = 1'b1;
          end else if (length_value_r < TV_BYTES) begin
            res.emit       = 1'b1;
            res.frame_last = 1'b1;
            res.status     = ST_SHORT;
            stuck_nxt      = 1'b1;
          end else if (length_value_r == TV_BYTES) begin
            res.emit       = 1'b1;
            res.frame_last = 1'b1;
            if (!version_good_r) begin
              res.status = ST_VERSION;
              stuck_nxt  = 1'b1;
            end else begin
              next_frame = 1'b1;
            end
          end else begin
            bytes_left_nxt = length_value_r - TV_BYTES;
            phase_nxt      = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          bytes_left_nxt = final_byte ? 32'd0 : bytes_left_r - 32'd1;
          if (!version_good_r) begin
            if (final_byte) begin
              res.emit       = 1'b1;
              res.frame_last = 1'b1;
              res.status     = ST_VERSION;
              stuck_nxt      = 1'b1;
            end
          end else begin
            res.emit         = 1'b1;
            res.payload_byte = data_byte;
            res.byte_valid   = 1'b1;
            res.frame_last   = final_byte;
            next_frame       = final_byte;
          end
        end
        default: begin
          next_frame = 1'b1;
        end
      endcase
    end

    res.message_type = frame_type_nxt;
    res.body_length  = length_value_r;

    if (next_frame) begin
      phase_nxt        = PH_LENGTH;
      header_index_nxt = 2'd0;
      length_value_nxt = 32'd0;
      bytes_left_nxt   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LENGTH;
      header_index_r <= 2'd0;
      length_value_r <= 32'd0;
      bytes_left_r   <= 32'd0;
      frame_type_r   <= 8'd0;
      version_good_r <= 1'b0;
      stuck_r        <= 1'b0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      header_index_r <= header_index_nxt;
      length_value_r <= length_value_nxt;
      bytes_left_r   <= bytes_left_nxt;
      frame_type_r   <= frame_type_nxt;
      version_good_r <= version_good_nxt;
      stuck_r        <= stuck_nxt;
    end
  end

  assign stuck = stuck_r;

endmodule

`default_nettype wire

/* rtl/length_prefixed_frame_deframer_top.sv */
// length-prefixed frame deframer
// in_*: one stream byte per transfer. each frame is a 4-byte body length
// (byte order set by length_big_endian), a version byte, a type byte and
// body length - 2 payload bytes
// out_*: at most one result per input byte: payload bytes tagged with the
// frame type, frame_last on the final one; length errors reported on the type
// byte, a bad version on the frame's final byte
// cfg_*: register writes (0 max_body, 1 expected_version, 2 length_big_endian),
// always ready; the user must write them only while the block is idle, it does not enforce this
// a result is presented the cycle after its byte's transfer
// throughput: one byte per cycle while the receiver keeps up, set by the single
// output register; a new byte is taken while the held result goes out in the same cycle
// when the receiver stalls with a result held, in_ready drops until it is taken
// after an error every further byte is taken and dropped until reset
// reset (synchronous, rst_n low): parser to the length phase, error cleared,
// output register empty, registers to 65536, 1 and big endian
`default_nettype none

module length_prefixed_frame_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_payload_byte,
  output logic             out_byte_valid,
  output logic [7:0]       out_message_type,
  output logic             out_frame_last,
  output logic [1:0]       out_status,
  output logic [31:0]      out_body_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import lpfd_pkg::*;

  cfg_t    cfg_r;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    in_accept;
  logic    load;
  logic    stuck;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_body          <= 32'd65536;
      cfg_r.expected_version  <= 8'd1;
      cfg_r.length_big_endian <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_BODY:    cfg_r.max_body          <= cfg_data;
        CFG_EXP_VERSION: cfg_r.expected_version  <= cfg_data[7:0];
        CFG_BIG_ENDIAN:  cfg_r.length_big_endian <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign load      = in_accept && res.emit;

  lpfd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .cfg       (cfg_r),
    .res       (res),
    .stuck     (stuck)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_valid   = out_r.byte_valid;
  assign out_message_type = out_r.message_type;
  assign out_frame_last   = out_r.frame_last;
  assign out_status       = out_r.status;
  assign out_body_length  = out_r.body_length;

  // nothing leaves the parser once an error has stuck
  assert property (@(posedge clk) disable iff (!rst_n) stuck |-> !res.emit)
    else $error("result raised after sticky error");

  // an error result always closes the frame and carries no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |-> (out_r.frame_last && !out_r.byte_valid))
    else $error("error result without frame_last or with a byte");

  // every error result is followed by the sticky state
  assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.status != ST_OK) |=> stuck)
    else $error("error reported without going stuck");

  // a held result is not overwritten before its transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

/* tb/sv/frame_checker.sv */
`timescale 1ns / 100ps

module frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_byte_valid,
  input  logic [7:0]  out_message_type,
  input  logic        out_frame_last,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_body_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          awaiting,
  output int          results_seen,
  output int          frames_done
);
  import lpfd_pkg::*;

  typedef enum logic [1:0] {
    WANT_LENGTH,
    WANT_VERSION,
    WANT_TYPE,
    WANT_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]  payload;
    logic        byte_valid;
    logic [7:0]  mtype;
    logic        last;
    status_t     status;
    logic [31:0] blen;
  } deframed_t;

  deframed_t    due_q[$];

  logic [31:0]  lim_body;
  logic [7:0]   want_version;
  logic         msb_first;

  parse_phase_t parse_phase;
  logic [1:0]   len_index;
  logic [31:0]  body_len;
  logic [31:0]  remaining;
  logic [7:0]   cur_type;
  logic         version_ok;
  logic         locked;

  int n_fail = 0;
  int n_results = 0;
  int n_frames = 0;

  function automatic string show(input deframed_t r);
    return $sformatf("byte %02h valid %0b type %02h last %0b status %0d length %0d",
                     r.payload, r.byte_valid, r.mtype, r.last, r.status, r.blen);
  endfunction

  function automatic void queue_result(input logic [7:0] pb, input logic vld,
                                       input logic last, input status_t st);
    deframed_t r;
    r.payload    = pb;
    r.byte_valid = vld;
    r.mtype      = cur_type;
    r.last       = last;
    r.status     = st;
    r.blen       = body_len;
    due_q.push_back(r);
  endfunction

  function automatic void start_frame();
    parse_phase = WANT_LENGTH;
    len_index   = 2'd0;
    body_len    = 32'd0;
    remaining   = 32'd0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic final_byte;
    if (locked) return;
    case (parse_phase)
      WANT_LENGTH: begin
        if (msb_first) body_len = {body_len[23:0], b};
        else body_len = body_len | ({24'd0, b} << (8 * len_index));
        if (len_index == 2'd3) begin
          len_index   = 2'd0;
          parse_phase = WANT_VERSION;
        end else begin
          len_index = len_index + 2'd1;
        end
      end
      WANT_VERSION: begin
        version_ok  = (b == want_version);
        parse_phase = WANT_TYPE;
      end
      WANT_TYPE: begin
        cur_type = b;
        if (body_len > lim_body) begin
          queue_result(8'd0, 1'b0, 1'b1, ST_LONG);
          locked = 1'b1;
        end else if (body_len < TYPE_VERSION_BYTES) begin
          queue_result(8'd0, 1'b0, 1'b1, ST_SHORT);
          locked = 1'b1;
        end else if (body_len == TYPE_VERSION_BYTES) begin
          if (!version_ok) begin
            queue_result(8'd0, 1'b0, 1'b1, ST_VERSION);
            locked = 1'b1;
          end else begin
            queue_result(8'd0, 1'b0, 1'b1, ST_OK);
            start_frame();
          end
        end else begin
          remaining   = body_len - TYPE_VERSION_BYTES;
          parse_phase = WANT_PAYLOAD;
        end
      end
      default: begin
        final_byte = (remaining <= 32'd1);
        remaining  = final_byte ? 32'd0 : remaining - 32'd1;
        if (!version_ok) begin
          if (final_byte) begin
            queue_result(8'd0, 1'b0, 1'b1, ST_VERSION);
            locked = 1'b1;
          end
        end else begin
          queue_result(b, 1'b1, final_byte, ST_OK);
          if (final_byte) start_frame();
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    deframed_t got;
    deframed_t want;
    if (!rst_n) begin
      lim_body     = 32'd65536;
      want_version = 8'd1;
      msb_first    = 1'b1;
      start_frame();
      cur_type     = 8'd0;
      version_ok   = 1'b0;
      locked       = 1'b0;
      due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_payload_byte, out_byte_valid, out_message_type, out_frame_last,
                status_t'(out_status), out_body_length};
        n_results++;
        if (got.last && got.status == ST_OK) n_frames++;
        if (due_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_BODY:    lim_body     = cfg_data;
          CFG_EXP_VERSION: want_version = cfg_data[7:0];
          CFG_BIG_ENDIAN:  msb_first    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) deframe_byte(in_data_byte);
    end
    awaiting     <= due_q.size();
    fail_count   <= n_fail;
    results_seen <= n_results;
    frames_done  <= n_frames;
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import lpfd_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES = 600;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = 3;

  typedef enum logic [1:0] {
    END_TOO_LONG,
    END_TOO_SHORT,
    END_BAD_VERSION_EMPTY,
    END_BAD_VERSION_PAYLOAD
  } closing_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_byte_valid;
  logic [7:0]  out_message_type;
  logic        out_frame_last;
  logic [1:0]  out_status;
  logic [31:0] out_body_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  int fail_count;
  int awaiting;
  int results_seen;
  int frames_done;

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  logic [31:0] cur_max = 32'd65536;
  logic [7:0]  cur_version = 8'd1;
  logic        cur_big = 1'b1;
  int          bytes_sent = 0;
  int          settings = 1;

  length_prefixed_frame_deframer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_message_type (out_message_type),
    .out_frame_last   (out_frame_last),
    .out_status       (out_status),
    .out_body_length  (out_body_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  frame_checker frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_message_type (out_message_type),
    .out_frame_last   (out_frame_last),
    .out_status       (out_status),
    .out_body_length  (out_body_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .awaiting         (awaiting),
    .results_seen     (results_seen),
    .frames_done      (frames_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // caller lowers cfg_valid once the group of writes is done
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] mx, input logic [7:0] ver, input logic big);
    drain();
    reg_write(CFG_MAX_BODY, mx);
    reg_write(CFG_EXP_VERSION, {24'd0, ver});
    reg_write(CFG_BIG_ENDIAN, {31'd0, big});
    cfg_valid   <= 1'b0;
    cur_max     = mx;
    cur_version = ver;
    cur_big     = big;
    settings++;
  endtask

  task automatic send_frame(input logic [31:0] blen, input logic [7:0] ver,
                            input logic [7:0] mtype, input int npay);
    for (int i = 0; i < 4; i++)
      send_byte(cur_big ? blen[31 - 8 * i -: 8] : blen[8 * i +: 8]);
    send_byte(ver);
    send_byte(mtype);
    for (int i = 0; i < npay; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_frame();
    int room;
    int npay;
    int pick;
    if (cur_max > 32'd42) room = 40;
    else room = int'(cur_max) - 2;
    pick = $urandom_range(0, 7);
    if (pick == 0) npay = room;
    else if (pick == 1) npay = $urandom_range(0, room);
    else npay = $urandom_range(0, (room < 12) ? room : 12);
    send_frame(32'(npay + 2), cur_version, 8'($urandom_range(0, 255)), npay);
  endtask

  // receiver: random stalls per result, one long hold-off on request
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    closing_t closing;
    int       target;
    int       npay;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one payload byte at the low extreme, then an empty frame
    send_frame(32'd3, 8'd1, 8'hFF, 0);
    send_byte(8'h00);
    send_frame(32'd2, 8'd1, 8'h00, 0);

    // byte order flipped halfway through the length field
    send_byte(8'h00);
    send_byte(8'h05);
    drain();
    reg_write(CFG_BIG_ENDIAN, 32'd0);
    reg_write(CFG_SPARE, $urandom());
    cfg_valid <= 1'b0;
    cur_big = 1'b0;
    settings++;
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h01);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: program_regs(32'd2, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1: program_regs(32'hFFFF_FFFF, 8'd0, 1'b1);
        2: program_regs(32'd65536, 8'd255, 1'b0);
        default: program_regs(32'($urandom_range(2, 60)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
      endcase
      no_idle = (p % 3 == 1);
      if (p == 4) hold_req = 1'b1;
      target = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
      while (bytes_sent < target) random_frame();
    end
    no_idle = 1'b0;

    // one error closes the stream for good
    closing = closing_t'($urandom_range(0, 3));
    case (closing)
      END_TOO_LONG: begin
        program_regs(32'($urandom_range(2, 1000)), cur_version, cur_big);
        send_frame(32'($urandom()) | 32'h0001_0000, cur_version,
                   8'($urandom_range(0, 255)), 0);
      end
      END_TOO_SHORT:
        send_frame(32'($urandom_range(0, 1)), cur_version, 8'($urandom_range(0, 255)), 0);
      END_BAD_VERSION_EMPTY:
        send_frame(32'd2, cur_version ^ 8'($urandom_range(1, 255)),
                   8'($urandom_range(0, 255)), 0);
      default: begin
        program_regs(32'd65536, cur_version, cur_big);
        npay = $urandom_range(1, 20);
        send_frame(32'(npay + 2), cur_version ^ 8'($urandom_range(1, 255)),
                   8'($urandom_range(0, 255)), npay);
      end
    endcase
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    drain();

    $display("%0d stream bytes over %0d register settings, %0d results checked, %0d frames whole",
             bytes_sent, settings, results_seen, frames_done);
    $display("stream closed by %s, later bytes dropped, %0d mismatches",
             closing.name(), fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lpfd_pkg.sv
rtl/lpfd_parse.sv
rtl/length_prefixed_frame_deframer_top.sv
tb/sv/frame_checker.sv
tb/sv/testbench.sv
